/* hw/rtl/uves_pkg.sv */
// shared types and constants for the uv edge straightener
package uves_pkg;

	localparam int COORD_BITS  = 24;
	localparam int ID_BITS     = 16;
	localparam int SIDES_BITS  = 3;
	localparam int EDGE_BITS   = 2;
	localparam int N_CORNERS   = 4;
	localparam int NORM_BITS   = 62;
	localparam int NORM_PAIRS  = 31;
	localparam int TARGET_PAIR = 30;
	localparam int ROOT_BITS   = 31;
	localparam int SHIFT_BITS  = 5;
	localparam int GROUP_PAIRS = 8;
	localparam int N_GROUPS    = 4;
	localparam int GIDX_BITS   = 3;
	localparam int GSEL_BITS   = 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [ID_BITS-1:0]    polygon_id;
		logic [SIDES_BITS-1:0] side_count;
		logic [EDGE_BITS-1:0]  edge_index;
		coord_t                c0_u;
		coord_t                c0_v;
		coord_t                c1_u;
		coord_t                c1_v;
		coord_t                c2_u;
		coord_t                c2_v;
		coord_t                c3_u;
		coord_t                c3_v;
	} in_item_t;

	typedef struct packed {
		logic [ID_BITS-1:0] out_polygon_id;
		coord_t             r0_u;
		coord_t             r0_v;
		coord_t             r1_u;
		coord_t             r1_v;
		coord_t             r2_u;
		coord_t             r2_v;
		coord_t             r3_u;
		coord_t             r3_v;
		logic               zero_edge;
	} out_item_t;

endpackage

/* hw/rtl/uves_sqrt_pipe.sv */
// pipelined integer square root, one root bit per stage, with sideband
module uves_sqrt_pipe #(
	parameter int SIDE_W = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [uves_pkg::NORM_BITS-1:0]    x,
	input  logic [SIDE_W-1:0]                 in_side,
	output logic                              out_valid,
	output logic [uves_pkg::ROOT_BITS-1:0]    root,
	output logic [SIDE_W-1:0]                 out_side
);
	localparam int RB = uves_pkg::ROOT_BITS;
	localparam int NB = uves_pkg::NORM_BITS;
	localparam int RW = RB + 2;

	logic [RW-1:0]     rem_q  [RB];
	logic [RB-1:0]     root_q [RB];
	logic [NB-1:0]     x_q    [RB];
	logic [SIDE_W-1:0] side_q [RB];
	logic [RB-1:0]     v_q;

	logic [RW-1:0]     rem_p  [RB];
	logic [RB-1:0]     root_p [RB];
	logic [NB-1:0]     x_p    [RB];
	logic [SIDE_W-1:0] side_p [RB];
	logic [RB-1:0]     v_p;

	for (genvar i = 0; i < RB; i++) begin : g_stage
		localparam int P = RB - 1 - i;
		logic [RW-1:0] sh;
		logic [RW-1:0] trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_p[i]  = '0;
			assign root_p[i] = '0;
			assign x_p[i]    = x;
			assign side_p[i] = in_side;
			assign v_p[i]    = in_valid;
		end else begin : g_next
			assign rem_p[i]  = rem_q[i-1];
			assign root_p[i] = root_q[i-1];
			assign x_p[i]    = x_q[i-1];
			assign side_p[i] = side_q[i-1];
			assign v_p[i]    = v_q[i-1];
		end

		assign sh    = {rem_p[i][RW-3:0], x_p[i][2*P +: 2]};
		assign trial = {root_p[i], 2'b01};
		assign ge    = sh >= trial;

		always_ff @(posedge clk) begin
			rem_q[i]  <= ge ? sh - trial : sh;
			root_q[i] <= {root_p[i][RB-2:0], ge};
			x_q[i]    <= x_p[i];
			side_q[i] <= side_p[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else begin
				v_q[i] <= v_p[i];
			end
		end
	end

	assign out_valid = v_q[RB-1];
	assign root      = root_q[RB-1];
	assign out_side  = side_q[RB-1];

endmodule

/* hw/rtl/uves_div_lane.sv */
// pipelined restoring divider lane, one quotient bit per stage
module uves_div_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                         clk,
	input  logic [uves_pkg::ROOT_BITS+FRAC_BITS:0]       num,
	input  logic [uves_pkg::ROOT_BITS-1:0]               den,
	output logic [FRAC_BITS:0]                           quot
);
	localparam int RB   = uves_pkg::ROOT_BITS;
	localparam int QB   = FRAC_BITS + 1;
	localparam int DN_W = RB + FRAC_BITS + 1;

	logic [RB-1:0]   rem_q [QB];
	logic [QB-1:0]   q_q   [QB];
	logic [DN_W-1:0] num_q [QB];
	logic [RB-1:0]   den_q [QB];

	logic [RB-1:0]   rem_p [QB];
	logic [QB-1:0]   q_p   [QB];
	logic [DN_W-1:0] num_p [QB];
	logic [RB-1:0]   den_p [QB];

	for (genvar j = 0; j < QB; j++) begin : g_stage
		localparam int B = QB - 1 - j;
		logic [RB:0] sh;
		logic        ge;

		if (j == 0) begin : g_first
			assign rem_p[j] = num[DN_W-1:QB];
			assign q_p[j]   = '0;
			assign num_p[j] = num;
			assign den_p[j] = den;
		end else begin : g_next
			assign rem_p[j] = rem_q[j-1];
			assign q_p[j]   = q_q[j-1];
			assign num_p[j] = num_q[j-1];
			assign den_p[j] = den_q[j-1];
		end

		assign sh = {rem_p[j], num_p[j][B]};
		assign ge = sh >= {1'b0, den_p[j]};

		always_ff @(posedge clk) begin
			rem_q[j] <= ge ? RB'(sh - {1'b0, den_p[j]}) : RB'(sh);
			q_q[j]   <= {q_p[j][QB-2:0], ge};
			num_q[j] <= num_p[j];
			den_q[j] <= den_p[j];
		end
	end

	assign quot = q_q[QB-1];

endmodule

/* hw/rtl/uves_rot_lane.sv */
// one corner lane: rotate about the midpoint, round and saturate
module uves_rot_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                    clk,
	input  logic signed [FRAC_BITS+1:0]             a,
	input  logic signed [FRAC_BITS+1:0]             b,
	input  logic signed [uves_pkg::COORD_BITS+1:0]  x2,
	input  logic signed [uves_pkg::COORD_BITS+1:0]  y2,
	input  logic signed [uves_pkg::COORD_BITS:0]    su,
	input  logic signed [uves_pkg::COORD_BITS:0]    sv,
	output uves_pkg::coord_t                        ru,
	output uves_pkg::coord_t                        rv
);
	localparam int C  = uves_pkg::COORD_BITS;
	localparam int AW = FRAC_BITS + 2;
	localparam int XW = C + 2;
	localparam int PW = AW + XW;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] HALF = SW'(1) <<< FRAC_BITS;
	localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (C - 1)) - SW'(1);
	localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

	logic signed [PW-1:0] pax_s1, pby_s1, pbx_s1, pay_s1;
	logic signed [C:0]    su_s1, sv_s1;
	logic signed [SW-1:0] nu, nv, tu, tv;

	always_ff @(posedge clk) begin
		pax_s1 <= a * x2;
		pby_s1 <= b * y2;
		pbx_s1 <= b * x2;
		pay_s1 <= a * y2;
		su_s1  <= su;
		sv_s1  <= sv;
	end

	assign nu = SW'(pax_s1) + SW'(pby_s1) + (SW'(su_s1) <<< FRAC_BITS) + HALF;
	assign nv = SW'(pay_s1) - SW'(pbx_s1) + (SW'(sv_s1) <<< FRAC_BITS) + HALF;
	assign tu = nu >>> (FRAC_BITS + 1);
	assign tv = nv >>> (FRAC_BITS + 1);

	always_ff @(posedge clk) begin
		if (tu > MAXV) begin
			ru <= MAXV[C-1:0];
		end else if (tu < MINV) begin
			ru <= MINV[C-1:0];
		end else begin
			ru <= tu[C-1:0];
		end
		if (tv > MAXV) begin
			rv <= MAXV[C-1:0];
		end else if (tv < MINV) begin
			rv <= MINV[C-1:0];
		end else begin
			rv <= tv[C-1:0];
		end
	end

endmodule

/* hw/rtl/uv_edge_axis_straighten.sv */
// uv edge straightener top level: edge normalise, fold, four rotation lanes
// throughput: one item per cycle; busy is low except right after reset
// the depth is set by the 31-stage root pipeline and the FRAC_BITS+1 stage dividers
// reset clears the valid chain and raises busy; the result strobe cannot be held off
module uv_edge_axis_straighten #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  uves_pkg::in_item_t  item,
	output logic                done,
	output uves_pkg::out_item_t result
);
	localparam int C      = uves_pkg::COORD_BITS;
	localparam int NB     = uves_pkg::NORM_BITS;
	localparam int RB     = uves_pkg::ROOT_BITS;
	localparam int KB     = uves_pkg::SHIFT_BITS;
	localparam int NC     = uves_pkg::N_CORNERS;
	localparam int AW     = FRAC_BITS + 2;
	localparam int QB     = FRAC_BITS + 1;
	localparam int DN_W   = RB + FRAC_BITS + 1;
	localparam int WIDE   = C + 1 + FRAC_BITS + 2 * uves_pkg::TARGET_PAIR + 1;
	localparam int LAT    = 5 + RB + 1 + QB + 1 + 2 + 1;

	typedef struct packed {
		logic [uves_pkg::ID_BITS-1:0] id;
		logic                         zero;
		logic [KB-1:0]                k;
		logic signed [C:0]            du;
		logic signed [C:0]            dv;
		logic signed [C:0]            su;
		logic signed [C:0]            sv;
		uves_pkg::coord_t [NC-1:0]    cu;
		uves_pkg::coord_t [NC-1:0]    cv;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

	logic busy_q;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	// edge selection
	uves_pkg::coord_t [NC-1:0] in_cu, in_cv;
	logic [uves_pkg::EDGE_BITS-1:0] e, nx;

	assign in_cu = {item.c3_u, item.c2_u, item.c1_u, item.c0_u};
	assign in_cv = {item.c3_v, item.c2_v, item.c1_v, item.c0_v};
	assign e     = item.edge_index;

	always_comb begin
		if (item.side_count > uves_pkg::SIDES_BITS'(3)) begin
			nx = e + uves_pkg::EDGE_BITS'(1);
		end else begin
			case (e)
				2'd0:    nx = 2'd1;
				2'd1:    nx = 2'd2;
				2'd2:    nx = 2'd0;
				default: nx = 2'd1;
			endcase
		end
	end

	logic  v_s1;
	side_t p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		p_s1.id   <= item.polygon_id;
		p_s1.zero <= 1'b0;
		p_s1.k    <= '0;
		p_s1.du   <= (C+1)'(in_cu[e]) - (C+1)'(in_cu[nx]);
		p_s1.dv   <= (C+1)'(in_cv[e]) - (C+1)'(in_cv[nx]);
		p_s1.su   <= (C+1)'(in_cu[e]) + (C+1)'(in_cu[nx]);
		p_s1.sv   <= (C+1)'(in_cv[e]) + (C+1)'(in_cv[nx]);
		p_s1.cu   <= in_cu;
		p_s1.cv   <= in_cv;
	end

	// squared length
	logic                   v_s2, v_s3, v_s4, v_s5;
	side_t                  p_s2, p_s3, p_s4, p_s5;
	side_t                  p_z, p_k;
	logic signed [2*C+1:0]  squ_s2, sqv_s2;
	logic [NB-1:0]          s_s3, s_s4, x_s5;
	logic [uves_pkg::N_GROUPS-1:0]  gnz_s4;
	logic [uves_pkg::GIDX_BITS-1:0] gidx_s4 [uves_pkg::N_GROUPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		p_z      = p_s2;
		p_z.zero = (p_s2.du == '0) && (p_s2.dv == '0);
	end

	always_ff @(posedge clk) begin
		squ_s2    <= p_s1.du * p_s1.du;
		sqv_s2    <= p_s1.dv * p_s1.dv;
		p_s2      <= p_s1;
		s_s3      <= NB'(squ_s2) + NB'(sqv_s2);
		p_s3      <= p_z;
	end

	// leading pair search, grouped
	logic [uves_pkg::N_GROUPS-1:0]  gnz;
	logic [uves_pkg::GIDX_BITS-1:0] gidx [uves_pkg::N_GROUPS];

	always_comb begin
		for (int g = 0; g < uves_pkg::N_GROUPS; g++) begin
			gnz[g]  = 1'b0;
			gidx[g] = '0;
			for (int jj = 0; jj < uves_pkg::GROUP_PAIRS; jj++) begin
				if (g * uves_pkg::GROUP_PAIRS + jj < uves_pkg::NORM_PAIRS) begin
					if (s_s3[2*(g*uves_pkg::GROUP_PAIRS+jj) +: 2] != 2'b00) begin
						gnz[g]  = 1'b1;
						gidx[g] = uves_pkg::GIDX_BITS'(jj);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		s_s4    <= s_s3;
		gnz_s4  <= gnz;
		gidx_s4 <= gidx;
		p_s4    <= p_s3;
	end

	logic [uves_pkg::GSEL_BITS-1:0] gsel;
	logic [KB-1:0]                  top_pair, kval;

	always_comb begin
		gsel = '0;
		for (int g = 0; g < uves_pkg::N_GROUPS; g++) begin
			if (gnz_s4[g]) begin
				gsel = uves_pkg::GSEL_BITS'(g);
			end
		end
		top_pair = {gsel, gidx_s4[gsel]};
		if (top_pair >= KB'(uves_pkg::TARGET_PAIR)) begin
			kval = '0;
		end else begin
			kval = KB'(uves_pkg::TARGET_PAIR) - top_pair;
		end
	end

	always_comb begin
		p_k   = p_s4;
		p_k.k = kval;
	end

	always_ff @(posedge clk) begin
		x_s5   <= s_s4 << {kval, 1'b0};
		p_s5   <= p_k;
	end

	// root
	logic              v_r;
	logic [RB-1:0]     root_r;
	logic [SIDE_W-1:0] side_r;
	side_t             p_r;

	uves_sqrt_pipe #(
		.SIDE_W (SIDE_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.x         (x_s5),
		.in_side   (SIDE_W'(p_s5)),
		.out_valid (v_r),
		.root      (root_r),
		.out_side  (side_r)
	);

	assign p_r = side_t'(side_r);

	// numerators for the two divider lanes
	logic [C:0]      magu, magv;
	logic [WIDE-1:0] wnu, wnv;
	logic            v_s6;
	side_t           p_s6;
	logic [DN_W-1:0] numu_s6, numv_s6;
	logic [RB-1:0]   den_s6;

	assign magu = p_r.du[C] ? (C+1)'(-p_r.du) : (C+1)'(p_r.du);
	assign magv = p_r.dv[C] ? (C+1)'(-p_r.dv) : (C+1)'(p_r.dv);
	assign wnu  = (WIDE'(magu) << (FRAC_BITS + int'(p_r.k))) + WIDE'(root_r >> 1);
	assign wnv  = (WIDE'(magv) << (FRAC_BITS + int'(p_r.k))) + WIDE'(root_r >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_r;
		end
	end

	always_ff @(posedge clk) begin
		numu_s6 <= wnu[DN_W-1:0];
		numv_s6 <= wnv[DN_W-1:0];
		den_s6  <= root_r;
		p_s6    <= p_r;
	end

	logic [QB-1:0] qu, qv;

	uves_div_lane #(
		.FRAC_BITS (FRAC_BITS)
	) u_div_u (
		.clk  (clk),
		.num  (numu_s6),
		.den  (den_s6),
		.quot (qu)
	);

	uves_div_lane #(
		.FRAC_BITS (FRAC_BITS)
	) u_div_v (
		.clk  (clk),
		.num  (numv_s6),
		.den  (den_s6),
		.quot (qv)
	);

	side_t p_d [QB];
	logic  v_d [QB];

	for (genvar j = 0; j < QB; j++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[j] <= 1'b0;
			end else begin
				v_d[j] <= (j == 0) ? v_s6 : v_d[(j == 0) ? 0 : j-1];
			end
		end
		always_ff @(posedge clk) begin
			p_d[j] <= (j == 0) ? p_s6 : p_d[(j == 0) ? 0 : j-1];
		end
	end

	// sign and quarter-turn fold
	side_t                pd;
	logic signed [AW-1:0] ua, ub, fa, fb;
	logic signed [AW:0]   fsum, fdif;

	assign pd   = p_d[QB-1];
	assign ua   = pd.du[C] ? -$signed({1'b0, qu}) : $signed({1'b0, qu});
	assign ub   = pd.dv[C] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
	assign fsum = (AW+1)'(ua) + (AW+1)'(ub);
	assign fdif = (AW+1)'(ua) - (AW+1)'(ub);

	always_comb begin
		fa = ua;
		fb = ub;
		if (fsum < 0) begin
			if (fdif < 0) begin
				fa = -ua;
				fb = -ub;
			end else begin
				fa = -ub;
				fb = ua;
			end
		end else if (!(fdif > 0)) begin
			fa = ub;
			fb = -ua;
		end
	end

	logic                 v_s7, v_s8, v_s9;
	side_t                p_s7, p_s8, p_s9;
	logic signed [AW-1:0] a_s7, b_s7;
	logic signed [C+1:0]  x2_s7 [NC];
	logic signed [C+1:0]  y2_s7 [NC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s7 <= v_d[QB-1];
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		a_s7 <= fa;
		b_s7 <= fb;
		p_s7 <= pd;
		for (int i = 0; i < NC; i++) begin
			x2_s7[i] <= ((C+2)'(pd.cu[i]) <<< 1) - (C+2)'(pd.su);
			y2_s7[i] <= ((C+2)'(pd.cv[i]) <<< 1) - (C+2)'(pd.sv);
		end
		p_s8 <= p_s7;
		p_s9 <= p_s8;
	end

	uves_pkg::coord_t ru [NC];
	uves_pkg::coord_t rv [NC];

	for (genvar i = 0; i < NC; i++) begin : g_lane
		uves_rot_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_rot (
			.clk (clk),
			.a   (a_s7),
			.b   (b_s7),
			.x2  (x2_s7[i]),
			.y2  (y2_s7[i]),
			.su  (p_s7.su),
			.sv  (p_s7.sv),
			.ru  (ru[i]),
			.rv  (rv[i])
		);
	end

	// merge lanes into the result
	uves_pkg::coord_t mu [NC];
	uves_pkg::coord_t mv [NC];

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			mu[i] = p_s9.zero ? p_s9.cu[i] : ru[i];
			mv[i] = p_s9.zero ? p_s9.cv[i] : rv[i];
		end
	end

	logic                done_q;
	uves_pkg::out_item_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		result_q.out_polygon_id <= p_s9.id;
		result_q.r0_u           <= mu[0];
		result_q.r0_v           <= mv[0];
		result_q.r1_u           <= mu[1];
		result_q.r1_v           <= mv[1];
		result_q.r2_u           <= mu[2];
		result_q.r2_v           <= mv[2];
		result_q.r3_u           <= mu[3];
		result_q.r3_v           <= mv[3];
		result_q.zero_edge      <= p_s9.zero;
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching item");

	a_accept_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted item produced no result");

	a_tag_kept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.out_polygon_id == $past(item.polygon_id, LAT))
		else $error("polygon tag mismatch");

	a_zero_edge_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.zero_edge) |-> result.r0_u == $past(item.c0_u, LAT))
		else $error("zero-length edge altered a corner");

endmodule
